@@ rtl/deq_pkg.sv @@
// Package for the double-ended queue: sizes, request opcodes and the
// command word that the top level broadcasts to every storage cell.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int COUNT_W    = $clog2(DEPTH + 1);
	localparam int OPCODE_W   = 3;

	// Request opcodes; the one unused code is a no-op that reports failure.
	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_CLEAR      = 3'd6
	} opcode_t;

	// Command seen by every cell in the same cycle. At most one strobe is high.
	typedef struct packed {
		logic                  ins_front;
		logic                  ins_back;
		logic                  rem_front;
		logic                  rem_back;
		logic                  clear;
		logic [DATA_WIDTH-1:0] push_value;
	} deq_cmd_t;

endpackage

@@ rtl/deq_if.sv @@
// Valid/ready channel interfaces for the double-ended queue: the request
// channel and the response channel. Depends on deq_pkg.
`timescale 1ns / 1ps

interface deq_req_if;
	import deq_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [OPCODE_W-1:0]          opcode;
	logic signed [DATA_WIDTH-1:0] push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_rsp_if;
	import deq_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] read_value;
	logic                         success;
	logic                         is_empty;
	logic                         is_full;
	logic [COUNT_W-1:0]           entry_count;

	modport source (output valid, output read_value, output success, output is_empty,
		output is_full, output entry_count, input ready);
	modport sink (input valid, input read_value, input success, input is_empty,
		input is_full, input entry_count, output ready);
endinterface

@@ rtl/deq_cell.sv @@
// One storage cell of the queue row: a word and an occupied flag, shifted
// toward either neighbor or loaded at the back boundary. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  deq_pkg::deq_cmd_t               cmd,
	input  logic [deq_pkg::DATA_WIDTH-1:0]  left_data,
	input  logic                            left_valid,
	input  logic [deq_pkg::DATA_WIDTH-1:0]  right_data,
	input  logic                            right_valid,
	output logic [deq_pkg::DATA_WIDTH-1:0]  data,
	output logic                            valid,
	output logic [deq_pkg::DATA_WIDTH-1:0]  tail_data
);
	import deq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  valid_q;
	logic                  is_tail;
	logic                  is_gap;

	// This cell holds the back entry, or is the first free place.
	assign is_tail = valid_q && !right_valid;
	assign is_gap  = !valid_q && left_valid;

	// Occupied flag: shifts with the data, cleared at the back on a pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.ins_front) begin
			valid_q <= left_valid;
		end else if (cmd.rem_front) begin
			valid_q <= right_valid;
		end else if (cmd.ins_back && is_gap) begin
			valid_q <= 1'b1;
		end else if (cmd.rem_back && is_tail) begin
			valid_q <= 1'b0;
		end
	end

	// Stored word: taken from a neighbor on a shift, or from the request.
	always_ff @(posedge clk) begin
		if (cmd.ins_front) begin
			data_q <= left_data;
		end else if (cmd.rem_front) begin
			data_q <= right_data;
		end else if (cmd.ins_back && is_gap) begin
			data_q <= cmd.push_value;
		end
	end

	assign data      = data_q;
	assign valid     = valid_q;
	assign tail_data = is_tail ? data_q : '0;

endmodule

@@ rtl/double_ended_queue.sv @@
// Top level of the double-ended queue: request decode, entry count, the
// row of storage cells and the response register. Depends on deq_pkg,
// deq_if and deq_cell.
`timescale 1ns / 1ps

// Usage
// The request channel (req) carries an opcode and a word to push; the
// response channel (rsp) returns exactly one result per request: the word
// popped or peeked, a success flag, and the empty flag, full flag and entry
// count as they stand after the request. Both are valid/ready channels and a
// transfer happens when valid and ready are high at a rising clock edge.
// Entries live in a row of DEPTH cells with the front entry in cell 0. A push
// or pop at the front shifts the whole row by one place; a push
// or pop at the back touches only the cell at the occupied boundary.
// The response is registered and appears in the cycle after the request
// transfer. Throughput: one request per cycle while responses are taken, set
// by the row shift; the back word is picked from the row by an OR over cells.
// If the receiver stalls, the response holds and req.ready stays low until it
// is taken; a new request is taken in the same cycle the old response leaves.
// Reset (arst_n low) empties the queue and drops any pending response; there
// is no clearing pass, the stored words are simply marked unoccupied.

module double_ended_queue (
	input  logic       clk,
	input  logic       arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);
	import deq_pkg::*;

	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    count_next;
	logic                  accept;
	logic                  empty;
	logic                  full;
	deq_cmd_t              cmd;
	deq_cmd_t              cmd_gated;
	logic                  ok;
	logic [DATA_WIDTH-1:0] rd_value;
	logic [DATA_WIDTH-1:0] front_data;
	logic [DATA_WIDTH-1:0] back_data;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic                  cell_valid [DEPTH];
	logic [DATA_WIDTH-1:0] cell_tail [DEPTH];

	logic                  rsp_valid_q;
	logic [DATA_WIDTH-1:0] read_value_q;
	logic                  success_q;
	logic [COUNT_W-1:0]    entry_count_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == COUNT_W'(DEPTH));

	// Front word sits in cell 0; the back word is the only unmasked tail output.
	assign front_data = cell_data[0];
	always_comb begin
		back_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_data = back_data | cell_tail[i];
		end
	end

	// Request decode: cell commands, result word, success and next count.
	always_comb begin
		cmd            = '0;
		cmd.push_value = req.push_value;
		ok             = 1'b0;
		rd_value       = '0;
		count_next     = count_q;
		case (opcode_t'(req.opcode))
			OP_PUSH_FRONT: begin
				if (!full) begin
					cmd.ins_front = 1'b1;
					ok            = 1'b1;
					count_next    = count_q + COUNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (!full) begin
					cmd.ins_back = 1'b1;
					ok           = 1'b1;
					count_next   = count_q + COUNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (!empty) begin
					cmd.rem_front = 1'b1;
					ok            = 1'b1;
					rd_value      = front_data;
					count_next    = count_q - COUNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (!empty) begin
					cmd.rem_back = 1'b1;
					ok           = 1'b1;
					rd_value     = back_data;
					count_next   = count_q - COUNT_W'(1);
				end
			end
			OP_PEEK_FRONT: begin
				if (!empty) begin
					ok       = 1'b1;
					rd_value = front_data;
				end
			end
			OP_PEEK_BACK: begin
				if (!empty) begin
					ok       = 1'b1;
					rd_value = back_data;
				end
			end
			OP_CLEAR: begin
				cmd.clear  = 1'b1;
				ok         = 1'b1;
				count_next = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Cells only act on a request that transfers in this cycle.
	always_comb begin
		cmd_gated            = '0;
		cmd_gated.push_value = cmd.push_value;
		if (accept) begin
			cmd_gated = cmd;
		end
	end

	// Row of cells; cell 0 is the front, its left neighbor is the request word.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic                  left_valid;
		logic [DATA_WIDTH-1:0] right_data;
		logic                  right_valid;

		if (g == 0) begin : g_first
			assign left_data  = req.push_value;
			assign left_valid = 1'b1;
		end else begin : g_inner_left
			assign left_data  = cell_data[g-1];
			assign left_valid = cell_valid[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_data  = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner_right
			assign right_data  = cell_data[g+1];
			assign right_valid = cell_valid[g+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd_gated),
			.left_data   (left_data),
			.left_valid  (left_valid),
			.right_data  (right_data),
			.right_valid (right_valid),
			.data        (cell_data[g]),
			.valid       (cell_valid[g]),
			.tail_data   (cell_tail[g])
		);
	end

	// Entry count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload, loaded with each request transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= rd_value;
			success_q     <= ok;
			entry_count_q <= count_next;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.success     = success_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.is_empty    = (entry_count_q == '0);
	assign rsp.is_full     = (entry_count_q == COUNT_W'(DEPTH));

endmodule

@@ rtl/deq_checker.sv @@
// Port-level checks for the double-ended queue and the bind that attaches
// them to the top level. Depends on deq_pkg and double_ended_queue.
`timescale 1ns / 1ps

module deq_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic                         success,
	input  logic                         is_empty,
	input  logic                         is_full,
	input  logic [deq_pkg::COUNT_W-1:0]  entry_count
);
	import deq_pkg::*;

	// Every request transfer yields a response in the next cycle.
	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response after a request transfer");

	// The status flags agree with the reported count.
	a_flags_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (entry_count == '0)) &&
			(is_full == (entry_count == COUNT_W'(DEPTH))))
		else $error("empty or full flag disagrees with entry count");

	// The count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= COUNT_W'(DEPTH))
		else $error("entry count above capacity");

	// A stalled response holds its status.
	a_rsp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count) && $stable(success))
		else $error("stalled response changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.success     (rsp.success),
	.is_empty    (rsp.is_empty),
	.is_full     (rsp.is_full),
	.entry_count (rsp.entry_count)
);

@@ tb/double_ended_queue_checker.sv @@
// Result checker for the double-ended queue: watches both channels, keeps a
// ring model of the queue, predicts each result and compares it field by field.
// Depends on deq_pkg and the channel interfaces in deq_if.
`timescale 1ns / 1ps

module double_ended_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	deq_req_if          req,
	deq_rsp_if          rsp,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned checked,
	output int unsigned reads_done,
	output int unsigned empty_refusals,
	output int unsigned full_refusals,
	output int unsigned clears
);
	import deq_pkg::*;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         ok;
		logic                         empty;
		logic                         full;
		logic [COUNT_W-1:0]           count;
	} deq_result_t;

	// Ring model of the queue: stored words, front position and fill level.
	logic signed [DATA_WIDTH-1:0] ring [DEPTH];
	int unsigned                  head;
	int unsigned                  held;

	// Results predicted for accepted requests, oldest first.
	deq_result_t owed_results [$];

	function automatic int unsigned slot(input int unsigned offset);
		return (head + offset) % DEPTH;
	endfunction

	// Apply one request to the ring model and work out the result it returns.
	task automatic apply_request(input logic [OPCODE_W-1:0] code,
		input logic signed [DATA_WIDTH-1:0] word, output deq_result_t res);
		bit is_read;
		bit is_push;
		res = '0;
		is_read = 1'b0;
		is_push = 1'b0;
		case (code)
			OP_PUSH_FRONT: begin
				is_push = 1'b1;
				if (held < DEPTH) begin
					head = slot(DEPTH - 1);
					ring[head] = word;
					held++;
					res.ok = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				is_push = 1'b1;
				if (held < DEPTH) begin
					ring[slot(held)] = word;
					held++;
					res.ok = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				is_read = 1'b1;
				if (held > 0) begin
					res.value = ring[head];
					head = slot(1);
					held--;
					res.ok = 1'b1;
				end
			end
			OP_POP_BACK: begin
				is_read = 1'b1;
				if (held > 0) begin
					res.value = ring[slot(held - 1)];
					held--;
					res.ok = 1'b1;
				end
			end
			OP_PEEK_FRONT: begin
				is_read = 1'b1;
				if (held > 0) begin
					res.value = ring[head];
					res.ok = 1'b1;
				end
			end
			OP_PEEK_BACK: begin
				is_read = 1'b1;
				if (held > 0) begin
					res.value = ring[slot(held - 1)];
					res.ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				held = 0;
				head = 0;
				res.ok = 1'b1;
				clears++;
			end
			default: begin
				// The unused opcode changes nothing and reports failure.
			end
		endcase
		if (is_read && res.ok)
			reads_done++;
		if (is_read && !res.ok)
			empty_refusals++;
		if (is_push && !res.ok)
			full_refusals++;
		res.empty = (held == 0);
		res.full  = (held == DEPTH);
		res.count = COUNT_W'(held);
	endtask

	task automatic note_mismatch(input string field, input logic signed [63:0] want_v,
		input logic signed [63:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field,
				want_v, got_v);
	endtask

	// Check each response transfer against the oldest prediction, then predict
	// the result of any request transfer at the same edge.
	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		deq_result_t predicted;
		if (!arst_n) begin
			head = 0;
			held = 0;
			owed_results.delete();
			outstanding    = 0;
			mismatches     = 0;
			checked        = 0;
			reads_done     = 0;
			empty_refusals = 0;
			full_refusals  = 0;
			clears         = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				checked++;
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] result transfer with no request waiting", $realtime);
				end else begin
					want = owed_results[0];
					owed_results.delete(0);
					if (rsp.read_value !== want.value)
						note_mismatch("read_value", want.value, rsp.read_value);
					if (rsp.success !== want.ok)
						note_mismatch("success", want.ok, rsp.success);
					if (rsp.is_empty !== want.empty)
						note_mismatch("is_empty", want.empty, rsp.is_empty);
					if (rsp.is_full !== want.full)
						note_mismatch("is_full", want.full, rsp.is_full);
					if (rsp.entry_count !== want.count)
						note_mismatch("entry_count", want.count, rsp.entry_count);
				end
			end
			if (req.valid && req.ready) begin
				apply_request(req.opcode, req.push_value, predicted);
				owed_results.insert(owed_results.size(), predicted);
			end
			outstanding = owed_results.size();
		end
	end

endmodule

@@ tb/double_ended_queue_tb.sv @@
// Testbench top for the double-ended queue: clock, reset, request stimulus
// and response back-pressure, with the result checker beside the block.
// Depends on deq_pkg, deq_if, double_ended_queue and double_ended_queue_checker.
`timescale 1ns / 1ps

module double_ended_queue_tb;
	import deq_pkg::*;

	localparam int TOTAL_ITEMS = 1450;
	localparam int LONG_HOLD   = 200;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MODE_FILL   = 0;
	localparam int MODE_DRAIN  = 1;
	localparam int MODE_MIXED  = 2;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
	localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	logic        clk;
	logic        arst_n;
	bit          steady;
	int unsigned sent;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned checked;
	int unsigned reads_done;
	int unsigned empty_refusals;
	int unsigned full_refusals;
	int unsigned clears;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	double_ended_queue_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.checked        (checked),
		.reads_done     (reads_done),
		.empty_refusals (empty_refusals),
		.full_refusals  (full_refusals),
		.clears         (clears)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length for either side: mostly none or short, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random word with extra weight on the extremes.
	function automatic logic signed [DATA_WIDTH-1:0] draw_word();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Opcode mix depends on whether the queue is being filled, drained or churned.
	function automatic logic [OPCODE_W-1:0] draw_request(input int mode);
		int unsigned r;
		int unsigned push_pct;
		int unsigned pop_pct;
		int unsigned peek_pct;
		bit          at_back;
		case (mode)
			MODE_FILL: begin
				push_pct = 80; pop_pct = 8; peek_pct = 11;
			end
			MODE_DRAIN: begin
				push_pct = 15; pop_pct = 75; peek_pct = 9;
			end
			default: begin
				push_pct = 40; pop_pct = 35; peek_pct = 20;
			end
		endcase
		r = $urandom_range(99);
		at_back = 1'($urandom_range(1));
		if (r < push_pct)
			return at_back ? OP_PUSH_BACK : OP_PUSH_FRONT;
		if (r < push_pct + pop_pct)
			return at_back ? OP_POP_BACK : OP_POP_FRONT;
		if (r < push_pct + pop_pct + peek_pct)
			return at_back ? OP_PEEK_BACK : OP_PEEK_FRONT;
		if (r < 99)
			return OP_CLEAR;
		return OP_UNUSED;
	endfunction

	// Offer one request from a falling edge and wait for its transfer; an
	// idle gap may follow before the next one.
	task automatic send_request(input logic [OPCODE_W-1:0] code,
		input logic signed [DATA_WIDTH-1:0] word);
		int unsigned gap;
		req_ch.valid      = 1'b1;
		req_ch.opcode     = code;
		req_ch.push_value = word;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		sent++;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Response back-pressure, with one long hold-off halfway through the run.
	initial begin
		int unsigned stall;
		bit          held_off;
		held_off = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held_off && sent >= TOTAL_ITEMS / 2) begin
				held_off = 1'b1;
				stall = LONG_HOLD;
			end else begin
				stall = pick_gap();
			end
			if (stall != 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			@(negedge clk);
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
			outstanding);
		$display("double_ended_queue test failed");
		$finish;
	end

	initial begin
		int          mode;
		int unsigned seg_len;
		bit          first_segment;
		arst_n            = 1'b0;
		steady            = 1'b0;
		sent              = 0;
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_PUSH_FRONT;
		req_ch.push_value = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reads on an empty queue, extreme words at both ends,
		// the unused opcode and a clear.
		send_request(OP_PEEK_FRONT, draw_word());
		send_request(OP_PEEK_BACK, draw_word());
		send_request(OP_POP_FRONT, draw_word());
		send_request(OP_POP_BACK, draw_word());
		send_request(OP_UNUSED, WORD_MAX);
		send_request(OP_PUSH_BACK, WORD_MAX);
		send_request(OP_PUSH_FRONT, WORD_MIN);
		send_request(OP_PUSH_BACK, '0);
		send_request(OP_PUSH_FRONT, '1);
		send_request(OP_PEEK_FRONT, WORD_MIN);
		send_request(OP_PEEK_BACK, WORD_MAX);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_FRONT, '1);
		send_request(OP_UNUSED, WORD_MIN);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_PUSH_BACK, draw_word());
		send_request(OP_PUSH_FRONT, draw_word());
		send_request(OP_CLEAR, draw_word());
		send_request(OP_PEEK_BACK, draw_word());
		send_request(OP_PUSH_FRONT, draw_word());
		send_request(OP_POP_BACK, draw_word());

		// Random segments; the first one fills the queue past full.
		first_segment = 1'b1;
		while (sent < TOTAL_ITEMS) begin
			mode = first_segment ? MODE_FILL : int'($urandom_range(2));
			seg_len = first_segment ? 120 : $urandom_range(30, 120);
			first_segment = 1'b0;
			steady = ($urandom_range(3) == 0);
			for (int i = 0; i < seg_len && sent < TOTAL_ITEMS; i++)
				send_request(draw_request(mode), draw_word());
		end
		req_ch.valid = 1'b0;
		steady = 1'b0;

		wait (outstanding == 0);
		repeat (4) @(posedge clk);
		$display("Ran %0d requests and checked %0d results: %0d reads returned data, %0d reads",
			sent, checked, reads_done, empty_refusals);
		$display("refused on an empty queue, %0d pushes refused when full, %0d clears.",
			full_refusals, clears);
		if (mismatches == 0 && outstanding == 0)
			$display("double_ended_queue test passed");
		else
			$display("double_ended_queue test failed");
		$finish;
	end

endmodule
